// ===== sv/mbe_pkg.sv =====
`default_nettype none

package mbe_pkg;

  // register indexes on the config port
  localparam logic [2:0] REG_ORIGIN_RE = 3'd0;
  localparam logic [2:0] REG_ORIGIN_IM = 3'd1;
  localparam logic [2:0] REG_STEP_RE   = 3'd2;
  localparam logic [2:0] REG_STEP_IM   = 3'd3;
  localparam logic [2:0] REG_MAX_ITER  = 3'd4;

  localparam logic [15:0] MAX_ITER_RESET = 16'd768;

  typedef struct packed {
    logic [63:0] origin_re;
    logic [63:0] origin_im;
    logic [62:0] step_re;
    logic [62:0] step_im;
    logic [15:0] max_iter;
  } mbe_cfg_t;

  // weight of a partial product inside the 128-bit accumulator
  typedef enum logic [1:0] {
    SH_0  = 2'd0,
    SH_32 = 2'd1,
    SH_64 = 2'd2
  } mbe_shift_t;

  typedef struct packed {
    logic        valid;
    logic        first;
    mbe_shift_t  shift;
    logic [31:0] a;
    logic [31:0] b;
  } mbe_mac_req_t;

endpackage

`default_nettype wire

// ===== sv/mbe_cfg.sv =====
`default_nettype none

module mbe_cfg import mbe_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  output mbe_cfg_t         cfg
);

  mbe_cfg_t cfg_r;
  mbe_cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_ORIGIN_RE: cfg_nxt.origin_re = cfg_data;
        REG_ORIGIN_IM: cfg_nxt.origin_im = cfg_data;
        REG_STEP_RE:   cfg_nxt.step_re   = cfg_data[62:0];
        REG_STEP_IM:   cfg_nxt.step_im   = cfg_data[62:0];
        REG_MAX_ITER:  cfg_nxt.max_iter  = cfg_data[15:0];
        default: ;  // unknown index: dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_re <= '0;
      cfg_r.origin_im <= '0;
      cfg_r.step_re   <= '0;
      cfg_r.step_im   <= '0;
      cfg_r.max_iter  <= MAX_ITER_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/mbe_mac.sv =====
`default_nettype none

// 32x32 multiplier, registered, feeding a 128-bit shift-accumulator
module mbe_mac import mbe_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire mbe_mac_req_t  req,
  output logic [127:0]       acc
);

  logic         valid_r;
  logic         first_r;
  mbe_shift_t   shift_r;
  logic [63:0]  prod_r;
  logic [127:0] acc_r;
  logic [127:0] acc_nxt;
  logic [127:0] addend;

  assign acc = acc_r;

  always_comb begin
    case (shift_r)
      SH_0:    addend = {64'd0, prod_r};
      SH_32:   addend = {32'd0, prod_r, 32'd0};
      SH_64:   addend = {prod_r, 64'd0};
      default: addend = '0;
    endcase
    acc_nxt = acc_r;
    if (valid_r) begin
      acc_nxt = (first_r ? 128'd0 : acc_r) + addend;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    first_r <= req.first;
    shift_r <= req.shift;
    prod_r  <= {32'd0, req.a} * {32'd0, req.b};
    acc_r   <= acc_nxt;
  end

endmodule

`default_nettype wire

// ===== sv/mandelbrot_escape_time.sv =====
// Mandelbrot escape-time unit. Each transfer on the input stream names a pixel
// (pixel_x, pixel_y); the unit maps it to c = origin + coord*step (signed
// Q4.59, saturated at the top of the 64-bit range), then iterates z = z*z + c
// starting at z = c, testing |z|^2 >= 4.0 before every pass, and returns one
// transfer with the pixel echoed and the pass count (max_iter if the point
// never escaped, 0 when max_iter is 0). All arithmetic runs through a single
// registered 32x32 multiplier with a 128-bit accumulator: each pass forms
// |r|^2, |i|^2 and |r|*|i| as twelve partial products. A pixel goes through
// coordinate mapping, then the passes, then a final limit or escape test,
// then the hand-off of the result. Only one pixel is in flight; in_tready is
// low from acceptance until the result is in the output register. The output
// register holds a finished result while the next pixel is computed.
// Registers (cfg_index): 0 origin_re, 1 origin_im, 2 step_re (63 bits),
// 3 step_im (63 bits), 4 max_iter (16 bits, reset 768); other indexes are
// ignored. Write them only while the unit is idle.
`default_nettype none

module mandelbrot_escape_time import mbe_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream, tdata: [8:0] pixel_x, [16:9] pixel_y, rest zero
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,
  // result stream, tdata: [8:0] out_x, [16:9] out_y, [32:17] iter_count,
  // rest zero
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,
  // config write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MAP  = 4'b0010,
    ST_ITER = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  // sequencer step numbers (shared by mapping and iteration)
  localparam logic [3:0] STEP_LIMIT   = 4'd0;   // limit test, operand magnitudes
  localparam logic [3:0] STEP_ISSUE0  = 4'd1;   // first partial product issued
  localparam logic [3:0] STEP_ISSUE11 = 4'd12;  // last partial product issued
  localparam logic [3:0] STEP_SQR     = 4'd6;   // first product complete
  localparam logic [3:0] STEP_SQI     = 4'd10;  // second product complete
  localparam logic [3:0] STEP_MAPPED  = 4'd11;  // form c, end of mapping
  localparam logic [3:0] STEP_TEST    = 4'd14;  // cross product complete, escape test
  localparam logic [3:0] STEP_UPDATE  = 4'd15;  // z = z*z + c

  localparam logic [63:0] SIGN64 = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX64  = 64'h7FFF_FFFF_FFFF_FFFF;

  // clamp a 65-bit signed sum into 64 bits
  function automatic logic [63:0] sat64(input logic [64:0] s);
    logic [63:0] res;
    if (s[64] != s[63]) begin
      res = s[64] ? SIGN64 : MAX64;
    end else begin
      res = s[63:0];
    end
    return res;
  endfunction

  // origin + product, product below 2^73; only the upper bound can be hit
  function automatic logic [63:0] map_sat(input logic [63:0] origin,
                                          input logic [72:0] prod);
    logic [73:0] sum;
    logic [63:0] res;
    sum = {10'd0, origin ^ SIGN64} + {1'b0, prod};
    if (|sum[73:64]) begin
      res = MAX64;
    end else begin
      res = sum[63:0] ^ SIGN64;
    end
    return res;
  endfunction

  mbe_cfg_t     cfg;
  mbe_mac_req_t mac_req;
  logic [127:0] mac_acc;

  state_t       state_r,   state_nxt;
  logic [3:0]   step_r,    step_nxt;
  logic [8:0]   px_r,      px_nxt;
  logic [7:0]   py_r,      py_nxt;
  // multiplier operands: prod0 = ma*mb, prod1 = mc*md, prod2 = ma*md
  logic [63:0]  ma_r,      ma_nxt;
  logic [63:0]  mb_r,      mb_nxt;
  logic [63:0]  mc_r,      mc_nxt;
  logic [63:0]  md_r,      md_nxt;
  logic [127:0] sqr_r,     sqr_nxt;
  logic [127:0] sqi_r,     sqi_nxt;
  logic [63:0]  cre_r,     cre_nxt;
  logic [63:0]  cim_r,     cim_nxt;
  logic [63:0]  r_r,       r_nxt;
  logic [63:0]  i_r,       i_nxt;
  logic [62:0]  ri_r,      ri_nxt;
  logic [61:0]  diff_r,    diff_nxt;
  logic [15:0]  n_r,       n_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic [8:0]   out_x_r,   out_x_nxt;
  logic [7:0]   out_y_r,   out_y_nxt;
  logic [15:0]  out_cnt_r, out_cnt_nxt;

  // partial-product issue
  logic [3:0]   pp_k;
  logic [63:0]  op_a;
  logic [63:0]  op_b;

  // escape test and update terms
  logic [60:0]  r2;
  logic [60:0]  i2;
  logic [61:0]  sq_sum;
  logic         escape;
  logic [60:0]  q;
  logic         frac_nz;
  logic [61:0]  ri_mag;
  logic [62:0]  ri_pos;
  logic [62:0]  ri_val;
  logic [64:0]  i_sum;
  logic [64:0]  r_sum;
  logic [63:0]  r_abs;
  logic [63:0]  i_abs;

  mbe_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mbe_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mac_req),
    .acc   (mac_acc)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_cnt_r, out_y_r, out_x_r};

  // twelve partial products per pass: three 64x64 products, four terms each
  always_comb begin
    pp_k          = step_r - STEP_ISSUE0;
    op_a          = (pp_k[3:2] == 2'd1) ? mc_r : ma_r;
    op_b          = (pp_k[3:2] == 2'd0) ? mb_r : md_r;
    mac_req.valid = ((state_r == ST_MAP) || (state_r == ST_ITER)) &&
                    (step_r >= STEP_ISSUE0) && (step_r <= STEP_ISSUE11);
    mac_req.first = (pp_k[1:0] == 2'd0);
    case (pp_k[1:0])
      2'd0: begin
        mac_req.a     = op_a[31:0];
        mac_req.b     = op_b[31:0];
        mac_req.shift = SH_0;
      end
      2'd1: begin
        mac_req.a     = op_a[31:0];
        mac_req.b     = op_b[63:32];
        mac_req.shift = SH_32;
      end
      2'd2: begin
        mac_req.a     = op_a[63:32];
        mac_req.b     = op_b[31:0];
        mac_req.shift = SH_32;
      end
      default: begin
        mac_req.a     = op_a[63:32];
        mac_req.b     = op_b[63:32];
        mac_req.shift = SH_64;
      end
    endcase
  end

  // |r|^2 and |i|^2 must stay below 2^120; cross product is then below 2^120 too
  assign r2      = sqr_r[119:59];
  assign i2      = sqi_r[119:59];
  assign sq_sum  = {1'b0, r2} + {1'b0, i2};
  assign escape  = (|sqr_r[127:120]) | (|sqi_r[127:120]) | sq_sum[61];
  assign q       = mac_acc[119:59];
  assign frac_nz = |mac_acc[58:0];
  assign ri_mag  = {1'b0, q} + {61'd0, frac_nz};
  assign ri_pos  = {1'b0, ri_mag};
  // cross term rounds toward minus infinity
  assign ri_val  = (r_r[63] ^ i_r[63]) ? (~ri_pos + 63'd1) : {2'b00, q};
  assign i_sum   = {ri_r[62], ri_r, 1'b0} + {cim_r[63], cim_r};
  assign r_sum   = {{3{diff_r[61]}}, diff_r} + {cre_r[63], cre_r};
  assign r_abs   = r_r[63] ? (~r_r + 64'd1) : r_r;
  assign i_abs   = i_r[63] ? (~i_r + 64'd1) : i_r;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    ma_nxt        = ma_r;
    mb_nxt        = mb_r;
    mc_nxt        = mc_r;
    md_nxt        = md_r;
    sqr_nxt       = sqr_r;
    sqi_nxt       = sqi_r;
    cre_nxt       = cre_r;
    cim_nxt       = cim_r;
    r_nxt         = r_r;
    i_nxt         = i_r;
    ri_nxt        = ri_r;
    diff_nxt      = diff_r;
    n_nxt         = n_r;
    out_valid_nxt = out_valid_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_cnt_nxt   = out_cnt_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          px_nxt    = in_tdata[8:0];
          py_nxt    = in_tdata[16:9];
          ma_nxt    = {55'd0, in_tdata[8:0]};
          mb_nxt    = {1'b0, cfg.step_re};
          mc_nxt    = {56'd0, in_tdata[16:9]};
          md_nxt    = {1'b0, cfg.step_im};
          step_nxt  = STEP_LIMIT;
          state_nxt = ST_MAP;
        end
      end
      ST_MAP: begin
        step_nxt = step_r + 4'd1;
        if (step_r == STEP_SQR) begin
          sqr_nxt = mac_acc;
        end
        if (step_r == STEP_SQI) begin
          sqi_nxt = mac_acc;
        end
        if (step_r == STEP_MAPPED) begin
          cre_nxt   = map_sat(cfg.origin_re, sqr_r[72:0]);
          cim_nxt   = map_sat(cfg.origin_im, sqi_r[72:0]);
          r_nxt     = cre_nxt;
          i_nxt     = cim_nxt;
          n_nxt     = '0;
          step_nxt  = STEP_LIMIT;
          state_nxt = ST_ITER;
        end
      end
      ST_ITER: begin
        step_nxt = step_r + 4'd1;
        case (step_r)
          STEP_LIMIT: begin
            if (n_r == cfg.max_iter) begin
              state_nxt = ST_DONE;
            end else begin
              ma_nxt = r_abs;
              mb_nxt = r_abs;
              mc_nxt = i_abs;
              md_nxt = i_abs;
            end
          end
          STEP_SQR: sqr_nxt = mac_acc;
          STEP_SQI: sqi_nxt = mac_acc;
          STEP_TEST: begin
            if (escape) begin
              state_nxt = ST_DONE;
            end else begin
              ri_nxt   = ri_val;
              diff_nxt = {1'b0, r2} - {1'b0, i2};
            end
          end
          STEP_UPDATE: begin
            i_nxt = sat64(i_sum);
            r_nxt = sat64(r_sum);
            n_nxt = n_r + 16'd1;
          end
          default: ;
        endcase
      end
      ST_DONE: begin
        // hand off once the output register is free or being drained
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_x_nxt     = px_r;
          out_y_nxt     = py_r;
          out_cnt_nxt   = n_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    px_r      <= px_nxt;
    py_r      <= py_nxt;
    ma_r      <= ma_nxt;
    mb_r      <= mb_nxt;
    mc_r      <= mc_nxt;
    md_r      <= md_nxt;
    sqr_r     <= sqr_nxt;
    sqi_r     <= sqi_nxt;
    cre_r     <= cre_nxt;
    cim_r     <= cim_nxt;
    r_r       <= r_nxt;
    i_r       <= i_nxt;
    ri_r      <= ri_nxt;
    diff_r    <= diff_nxt;
    n_r       <= n_nxt;
    out_x_r   <= out_x_nxt;
    out_y_r   <= out_y_nxt;
    out_cnt_r <= out_cnt_nxt;
  end

  // pass count never runs past the limit
  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ITER) |-> (n_r <= cfg.max_iter))
    else $error("pass count beyond max_iter");

  // an accepted pixel starts mapping and blocks further input
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> ((state_r == ST_MAP) && !in_tready))
    else $error("accepted pixel did not start mapping");

  // a result appears only out of the done state
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result loaded outside done state");

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`default_nettype none

module tb;
  import mbe_pkg::*;

  localparam int HALF_PERIOD = 5;
  localparam int RESET_CYCLES = 11;
  localparam int FRAC = 59;                        // Q4.59
  localparam longint CYCLE_LIMIT = 5_000_000;
  localparam int LONG_STALL = 1500;                // receiver hold-off, cycles
  localparam int MAX_SHOWN = 10;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_PIXELS = 95;
  localparam logic [2:0] REG_SPARE = 3'd7;         // no register at this index

  // pixel as it sits in in_tdata[16:0]
  typedef struct packed {
    logic [7:0] y;
    logic [8:0] x;
  } pixel_t;

  // result as it sits in out_tdata[32:0]
  typedef struct packed {
    logic [15:0] iters;
    logic [7:0]  y;
    logic [8:0]  x;
  } escape_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;     // [8:0] pixel_x, [16:9] pixel_y, rest zero
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;         // [8:0] out_x, [16:9] out_y, [32:17] iter_count
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  mandelbrot_escape_time uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // Our copy of the register file, updated on each accepted config transfer.
  logic signed [63:0] cur_origin_re = '0;
  logic signed [63:0] cur_origin_im = '0;
  logic [62:0]        cur_step_re = '0;
  logic [62:0]        cur_step_im = '0;
  logic [15:0]        cur_max_iter = MAX_ITER_RESET;

  pixel_t  pixels_to_send[$];      // filled by the sequence, drained by the driver
  escape_t expected_escapes[$];    // one per accepted pixel, oldest first

  int     in_idle_pct = 32;
  int     out_idle_pct = 32;
  logic   stall_kick = 1'b0;
  int     stall_left = 0;
  int     mismatches = 0;
  longint cycle_count = 0;

  // ---------------------------------------------------------------------------
  // Fixed-point model
  // ---------------------------------------------------------------------------

  // clamp a wide signed value into the signed 64-bit range
  function automatic logic signed [63:0] clamp64(input logic signed [127:0] v);
    logic signed [127:0] top;
    logic signed [127:0] bottom;
    top = 128'sh7FFF_FFFF_FFFF_FFFF;
    bottom = -top - 1;
    if (v > top) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (v < bottom) return {1'b1, 63'b0};
    return v[63:0];
  endfunction

  // origin + coord*step, exact, then saturated (only the top can be hit)
  function automatic logic signed [63:0] pixel_to_point(input logic signed [63:0] origin,
                                                        input logic [8:0] coord,
                                                        input logic [62:0] step);
    logic signed [127:0] o;
    logic signed [127:0] k;
    logic signed [127:0] s;
    o = origin;
    k = {119'b0, coord};
    s = {65'b0, step};
    return clamp64(o + k * s);
  endfunction

  // passes of z = z*z + c from z = c until |z|^2 >= 4 or the limit
  function automatic logic [15:0] escape_iters(input logic signed [63:0] c_re,
                                               input logic signed [63:0] c_im,
                                               input logic [15:0] limit);
    logic signed [127:0] zr;
    logic signed [127:0] zi;
    logic signed [127:0] rr;
    logic signed [127:0] ii;
    logic signed [127:0] ri;
    logic signed [127:0] four;
    logic [15:0]         n;
    logic                escaped;
    four = 128'sd1 <<< 61;
    zr = c_re;
    zi = c_im;
    n = '0;
    escaped = 1'b0;
    while (!escaped && n < limit) begin
      rr = (zr * zr) >>> FRAC;
      ii = (zi * zi) >>> FRAC;
      if (rr + ii >= four) begin
        escaped = 1'b1;
      end else begin
        ri = (zr * zi) >>> FRAC;            // floor, toward minus infinity
        zi = clamp64(2 * ri + c_im);
        zr = clamp64(rr - ii + c_re);
        n = n + 16'd1;
      end
    end
    return n;
  endfunction

  function automatic escape_t predict_escape(input pixel_t p);
    escape_t e;
    e.x = p.x;
    e.y = p.y;
    e.iters = escape_iters(pixel_to_point(cur_origin_re, p.x, cur_step_re),
                           pixel_to_point(cur_origin_im, {1'b0, p.y}, cur_step_im),
                           cur_max_iter);
    return e;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers queued pixels, idling at random while the sender is free.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else if (!in_tvalid || in_tready) begin
      if (pixels_to_send.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata  <= {7'b0, pixels_to_send.pop_front()};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted down here; kicked by the sequence.
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left <= 0;
    end else if (stall_kick) begin
      stall_left <= LONG_STALL;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  task automatic flag_mismatch(input string what, input longint unsigned want,
                               input longint unsigned got);
    if (mismatches < MAX_SHOWN)
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: checks result transfers first, then records the prediction for a
  // pixel accepted on the same edge (it cannot answer on that edge).
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    escape_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_escapes.size() == 0) begin
          flag_mismatch("unrequested result", 0, out_tdata);
        end else begin
          want = expected_escapes.pop_front();
          if (out_tdata[8:0] != want.x) flag_mismatch("out_x", want.x, out_tdata[8:0]);
          if (out_tdata[16:9] != want.y) flag_mismatch("out_y", want.y, out_tdata[16:9]);
          if (out_tdata[32:17] != want.iters)
            flag_mismatch("iter_count", want.iters, out_tdata[32:17]);
        end
      end
      if (in_tvalid && in_tready)
        expected_escapes.push_back(predict_escape(pixel_t'(in_tdata[16:0])));
      out_tready <= (stall_left == 0) && ($urandom_range(99) >= out_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence helpers
  // ---------------------------------------------------------------------------

  // one config transfer; valid stays up so writes can go back to back
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_ORIGIN_RE: cur_origin_re = value;
      REG_ORIGIN_IM: cur_origin_im = value;
      REG_STEP_RE:   cur_step_re = value[62:0];
      REG_STEP_IM:   cur_step_im = value[62:0];
      REG_MAX_ITER:  cur_max_iter = value[15:0];
      default: ;
    endcase
  endtask

  // full register load; unused upper bits carry junk, plus a write to a
  // spare index that must change nothing
  task automatic load_view(input logic [63:0] o_re, input logic [63:0] o_im,
                           input logic [63:0] s_re, input logic [63:0] s_im,
                           input logic [15:0] limit);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    @(posedge clk);
    write_reg(REG_ORIGIN_RE, o_re);
    write_reg(REG_ORIGIN_IM, o_im);
    write_reg(REG_STEP_RE, s_re);
    write_reg(REG_STEP_IM, s_im);
    write_reg(REG_MAX_ITER, {junk[63:16], limit});
    write_reg(REG_SPARE, {$urandom, $urandom});
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_pixel(input int x, input int y);
    pixel_t p;
    p.x = 9'(x);
    p.y = 8'(y);
    pixels_to_send.push_back(p);
  endtask

  // mostly inside the 320x200 image, some anywhere in the field range
  task automatic queue_random_pixels(input int count);
    @(negedge clk);
    repeat (count) begin
      if ($urandom_range(99) < 85)
        queue_pixel($urandom_range(319), $urandom_range(199));
      else
        queue_pixel($urandom_range(511), $urandom_range(255));
    end
  endtask

  // nothing queued, nothing offered, nothing outstanding; then a short pause
  // so the unit is back to idle before the next register write
  task automatic wait_drained();
    @(negedge clk);
    while (pixels_to_send.size() != 0 || in_tvalid || expected_escapes.size() != 0)
      @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [63:0] o_re;
    logic [63:0] o_im;
    logic [63:0] s_re;
    logic [63:0] s_im;
    logic [15:0] limit;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Reset registers: c = 0 for every pixel, so each runs the full 768.
    @(negedge clk);
    queue_pixel(0, 0);
    queue_pixel(511, 255);
    wait_drained();

    // Zero limit: count is 0 with no test, whatever the point.
    load_view(64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
              64'h7FFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 16'd0);
    @(negedge clk);
    queue_pixel(0, 0);
    queue_pixel(319, 199);
    queue_pixel(511, 255);
    queue_pixel(1, 1);
    wait_drained();

    // Most negative origins, largest steps, limit of one. (1,1) lands on a
    // tiny point and survives one pass; far pixels saturate the point.
    load_view(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000,
              64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, 16'd1);
    @(negedge clk);
    queue_pixel(0, 0);
    queue_pixel(1, 1);
    queue_pixel(2, 2);
    queue_pixel(511, 255);
    queue_pixel(1, 0);
    wait_drained();

    // Grid from -2-2i in steps of 0.5 at the largest limit; every pixel picked
    // escapes quickly. -2 and 2i sit exactly on |z|^2 = 4.
    load_view(64'hF000_0000_0000_0000, 64'hF000_0000_0000_0000,
              64'h0400_0000_0000_0000, 64'h0400_0000_0000_0000, 16'hFFFF);
    @(negedge clk);
    queue_pixel(0, 0);
    queue_pixel(5, 4);
    queue_pixel(6, 6);
    queue_pixel(8, 1);
    queue_pixel(3, 0);
    queue_pixel(0, 4);
    queue_pixel(4, 8);
    queue_pixel(511, 255);
    wait_drained();

    // Random views over the set with small limits to keep runtime bounded.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      limit = 16'($urandom_range(1, 64));
      o_re = -(64'sd5 <<< 58) + ({$urandom, $urandom} >> 5);   // -2.5 .. -1.5
      o_im = -(64'sd3 <<< 58) + ({$urandom, $urandom} >> 6);   // -1.5 .. -1.0
      s_re = ((64'd1 << 59) / $urandom_range(100, 400)) ^ 64'($urandom_range(255))
             ^ (64'($urandom_range(1)) << 63);
      s_im = ((64'd1 << 59) / $urandom_range(60, 250)) ^ 64'($urandom_range(255))
             ^ (64'($urandom_range(1)) << 63);
      case (phase)
        0: begin
          // back-to-back on both sides
          in_idle_pct <= 0;
          out_idle_pct <= 0;
        end
        1: limit = 16'($urandom_range(8, 32));
        2: begin
          // noise: any register contents, mostly instant escapes
          o_re = {$urandom, $urandom};
          o_im = {$urandom, $urandom};
          s_re = {$urandom, $urandom};
          s_im = {$urandom, $urandom};
        end
        3: begin
          // one point for the whole image
          s_re = '0;
          s_im = '0;
          limit = 16'($urandom_range(1, 40));
        end
        4: limit = 16'd100;
        6: begin
          // deep zoom: steps only in the low bits
          s_re = 64'($urandom) << $urandom_range(0, 28);
          s_im = 64'($urandom) << $urandom_range(0, 28);
          limit = 16'($urandom_range(1, 16));
        end
        default: ;
      endcase
      load_view(o_re, o_im, s_re, s_im, limit);

      if (phase == 1) begin
        // hold the receiver off while pixels keep coming: the result register
        // fills, then the input backs up
        @(negedge clk);
        stall_kick <= 1'b1;
        @(negedge clk);
        stall_kick <= 1'b0;
      end

      if (phase == 5) begin
        // sender goes quiet mid-phase until every result is back
        queue_random_pixels(PHASE_PIXELS / 2);
        wait_drained();
        queue_random_pixels(PHASE_PIXELS - PHASE_PIXELS / 2);
      end else begin
        queue_random_pixels(PHASE_PIXELS);
      end
      wait_drained();

      if (phase == 0) begin
        in_idle_pct <= 32;
        out_idle_pct <= 32;
      end
    end

    // let any stray transfer show up
    repeat (50) @(negedge clk);
    if (expected_escapes.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
sv/mbe_pkg.sv
sv/mbe_cfg.sv
sv/mbe_mac.sv
sv/mandelbrot_escape_time.sv
test/tb.sv
